/* sv/fce_pkg.sv */
// Shared types, constants and the convolutional code function of the framed encoder.
`default_nettype none

package fce_pkg;

  localparam int WORD_W    = 64;
  localparam int SHIFT_W   = 6;
  localparam int NIBBLE_W  = 4;
  localparam int PARAM_W   = 16;
  localparam int COUNT_W   = 32;

  localparam int ID_BITS_DEF       = 8;
  localparam int VALUE_BITS_DEF    = 16;
  localparam int OWN_MODULE_ID_DEF = 1;
  localparam int END_MARKER_ID_DEF = 255;

  // Parameter ids carried in a header word addressed to this block.
  localparam int PARAM_FRAME_LEN    = 0;
  localparam int PARAM_SYMBOL_COUNT = 2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA_LO,
    PH_DATA_HI
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic              last;
    logic              coded;
  } result_t;

  typedef struct packed {
    logic [SHIFT_W-1:0]  shift;
    logic [NIBBLE_W-1:0] nibble;
  } enc_t;

  // Encodes two input bits, bit 0 first. Shift bit 0 holds the newest bit.
  function automatic enc_t encode_pair(input logic [SHIFT_W-1:0] shift_in,
                                       input logic [1:0] bits);
    enc_t               r;
    logic [SHIFT_W-1:0] s;
    logic               ga;
    logic               gb;
    s = shift_in;
    r.nibble = '0;
    for (int j = 0; j < 2; j++) begin
      ga = bits[j] ^ s[1] ^ s[2] ^ s[4] ^ s[5];
      gb = bits[j] ^ s[0] ^ s[1] ^ s[2] ^ s[5];
      r.nibble[2*j]   = ga;
      r.nibble[2*j+1] = gb;
      s = {s[SHIFT_W-2:0], bits[j]};
    end
    r.shift = s;
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/fce_in_stage.sv */
// Input register that holds one item until the core has consumed it.
`default_nettype none

module fce_in_stage
  import fce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              word_valid,
  output logic                   word_stall,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic              consume,
  output logic                   held_valid,
  output logic [WORD_W-1:0]      held_word
);

  logic accept;

  // A new item may enter in the same cycle the held one is consumed.
  assign word_stall = held_valid && !consume;
  assign accept     = word_valid && !word_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (consume) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_word <= word;
    end
  end

endmodule

`default_nettype wire

/* sv/fce_core.sv */
// Header parsing, frame counting and convolutional encoding of the held item.
`default_nettype none

module fce_core
  import fce_pkg::*;
#(
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int OWN_MODULE_ID = OWN_MODULE_ID_DEF,
  parameter int END_MARKER_ID = END_MARKER_ID_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              held_valid,
  input  wire logic [WORD_W-1:0] held_word,
  output logic                   consume,
  output logic                   res_valid,
  output result_t                res,
  input  wire logic              res_ready
);

  localparam int ID_SHIFT = ID_BITS + VALUE_BITS;
  localparam logic [WORD_W-1:0] VALUE_MASK = (WORD_W'(1) << VALUE_BITS) - WORD_W'(1);

  phase_t              phase;
  phase_t              phase_next;
  logic [SHIFT_W-1:0]  code_shift;
  logic [SHIFT_W-1:0]  code_shift_next;
  logic [PARAM_W-1:0]  frame_len;
  logic [PARAM_W-1:0]  frame_len_next;
  logic [PARAM_W-1:0]  symbol_count;
  logic [PARAM_W-1:0]  symbol_count_next;
  logic [COUNT_W-1:0]  words_left;
  logic [COUNT_W-1:0]  words_left_next;

  logic [WORD_W-1:0]   hdr_id;
  logic [ID_BITS-1:0]  param_id;
  logic [COUNT_W-1:0]  param_id_ext;
  logic [PARAM_W-1:0]  value;
  logic                own_word;
  logic                end_word;
  logic [COUNT_W-1:0]  words_dec;
  enc_t                enc;

  assign hdr_id       = held_word >> ID_SHIFT;
  assign param_id     = held_word[VALUE_BITS +: ID_BITS];
  assign param_id_ext = COUNT_W'(param_id);
  assign value        = held_word[PARAM_W-1:0] & VALUE_MASK[PARAM_W-1:0];
  assign own_word     = hdr_id == WORD_W'(OWN_MODULE_ID);
  assign end_word     = hdr_id == WORD_W'(END_MARKER_ID);
  assign words_dec    = (words_left != '0) ? words_left - COUNT_W'(1) : words_left;
  assign enc          = encode_pair(code_shift,
                                    (phase == PH_DATA_HI) ? held_word[3:2] : held_word[1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      code_shift   <= '0;
      frame_len    <= '0;
      symbol_count <= '0;
      words_left   <= '0;
    end else begin
      phase        <= phase_next;
      code_shift   <= code_shift_next;
      frame_len    <= frame_len_next;
      symbol_count <= symbol_count_next;
      words_left   <= words_left_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    code_shift_next   = code_shift;
    frame_len_next    = frame_len;
    symbol_count_next = symbol_count;
    words_left_next   = words_left;
    consume           = 1'b0;
    res_valid         = 1'b0;
    res.word_out      = held_word;
    res.last          = 1'b1;
    res.coded         = 1'b0;

    case (phase)
      PH_HEADER: begin
        if (held_valid) begin
          if (!own_word) begin
            res_valid = 1'b1;
          end
          consume = own_word || res_ready;
          if (consume) begin
            if (own_word) begin
              if (param_id_ext == COUNT_W'(PARAM_FRAME_LEN)) begin
                frame_len_next = value;
              end else if (param_id_ext == COUNT_W'(PARAM_SYMBOL_COUNT)) begin
                symbol_count_next = value;
              end
            end
            // A word that is both a setting and the end marker sizes the frame with
            // the value it has just written.
            if (end_word) begin
              words_left_next = COUNT_W'(frame_len_next) * COUNT_W'(symbol_count_next);
              if (words_left_next != '0) begin
                phase_next = PH_DATA_LO;
              end
            end
          end
        end
      end
      PH_DATA_LO: begin
        res_valid    = held_valid;
        res.word_out = WORD_W'(enc.nibble);
        res.last     = 1'b0;
        res.coded    = 1'b1;
        if (held_valid && res_ready) begin
          code_shift_next = enc.shift;
          phase_next      = PH_DATA_HI;
        end
      end
      PH_DATA_HI: begin
        res_valid    = held_valid;
        res.word_out = WORD_W'(enc.nibble);
        res.last     = 1'b1;
        res.coded    = 1'b1;
        if (held_valid && res_ready) begin
          consume         = 1'b1;
          code_shift_next = enc.shift;
          words_left_next = words_dec;
          phase_next      = (words_dec == '0) ? PH_HEADER : PH_DATA_LO;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/fce_out_stage.sv */
// Result register that holds one result until the receiver takes it.
`default_nettype none

module fce_out_stage
  import fce_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         res_ready,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  assign res_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

/* sv/framed_convolutional_encoder_k7.sv */
// Usage:
// Input channel word_valid/word_stall carries 64-bit stream words. Output channel
// result_valid/result_stall carries word_out with last and coded flags.
// In the header phase a word whose module id is this block's id sets frame length
// or symbol count and yields no result; any other word is forwarded unchanged with
// coded low. An end-marker word closes the header; the next frame_len*symbol_count
// words are data words, and each yields two coded nibbles (bits 1:0, then 3:2),
// the second one flagged last.
// An accepted item passes the input register and then the result register before its
// first result. Both coded nibbles of a data word pass through the single result
// register, and the word stays in the input register until its second nibble is taken.
// Reset clears the phase, the code shift register, both frame parameters and the
// word counter; the shift register is not cleared between frames.
// While the receiver stalls, the result register holds its item and the input
// register keeps one more; settings for this block are still absorbed, and
// word_stall rises once the held item needs the result register.
`default_nettype none

module framed_convolutional_encoder_k7
  import fce_pkg::*;
#(
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int OWN_MODULE_ID = OWN_MODULE_ID_DEF,
  parameter int END_MARKER_ID = END_MARKER_ID_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              word_valid,
  output logic                   word_stall,
  input  wire logic [WORD_W-1:0] word,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [WORD_W-1:0]      word_out,
  output logic                   last,
  output logic                   coded
);

  logic              consume;
  logic              held_valid;
  logic [WORD_W-1:0] held_word;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           result;

  fce_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word       (word),
    .consume    (consume),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  fce_core #(
    .ID_BITS       (ID_BITS),
    .VALUE_BITS    (VALUE_BITS),
    .OWN_MODULE_ID (OWN_MODULE_ID),
    .END_MARKER_ID (END_MARKER_ID)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_word  (held_word),
    .consume    (consume),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  fce_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign word_out = result.word_out;
  assign last     = result.last;
  assign coded    = result.coded;

endmodule

`default_nettype wire

/* sv/fce_checker.sv */
// Port-level checks of the framed encoder and their binding to the top level.
`default_nettype none

module fce_checker
  import fce_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic [WORD_W-1:0] word_out,
  input wire logic              last,
  input wire logic              coded
);

  // A stalled result stays in place.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(word_out) && $stable(last)
      && $stable(coded))
    else $error("stalled result changed");

  // A coded result carries only one nibble.
  a_coded_narrow: assert property (@(posedge clk) disable iff (rst)
    result_valid && coded |-> word_out[WORD_W-1:NIBBLE_W] == '0)
    else $error("coded result wider than a nibble");

  // A forwarded header word is the only result of its item.
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !coded |-> last)
    else $error("forwarded header word without last");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result offered after reset");

endmodule

bind framed_convolutional_encoder_k7 fce_checker u_fce_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .word_out     (word_out),
  .last         (last),
  .coded        (coded)
);

`default_nettype wire
